// File: design/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and escape helpers for the JSON string
// escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int SIZE_W     = 13;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int IDX_W      = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
    // Largest count that can ever be stored (capacity of an 8191-byte area).
    localparam logic [SIZE_W-1:0] MAX_USED   = 13'd8190;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] HEX_ALPHA  = 8'h57;  // 'a' - 10

    localparam logic [IDX_W-1:0] LEN_PLAIN = 3'd1;
    localparam logic [IDX_W-1:0] LEN_SHORT = 3'd2;
    localparam logic [IDX_W-1:0] LEN_UNI   = 3'd6;

    typedef enum logic [1:0] {
        K_PLAIN,    // byte passes through
        K_SHORT,    // backslash + one char
        K_UNI,      // \u00hh
        K_TERM      // string terminator
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v < 4'd10) ? (CH_ZERO + w) : (HEX_ALPHA + w);
    endfunction

    // Classification of a nonzero source byte.
    function automatic t_cmd classify(input logic [7:0] b);
        t_cmd c;
        c.kind = K_PLAIN;
        c.data = b;
        unique case (b)
            CH_QUOTE:  begin c.kind = K_SHORT; c.data = CH_QUOTE;  end
            CH_BSLASH: begin c.kind = K_SHORT; c.data = CH_BSLASH; end
            CH_LF:     begin c.kind = K_SHORT; c.data = CH_N;      end
            CH_CR:     begin c.kind = K_SHORT; c.data = CH_R;      end
            CH_TAB:    begin c.kind = K_SHORT; c.data = CH_T;      end
            default: begin
                if (b < CTRL_LIMIT) begin
                    c.kind = K_UNI;
                end
            end
        endcase
        return c;
    endfunction

    function automatic logic [IDX_W-1:0] esc_len(input t_kind k);
        logic [IDX_W-1:0] n;
        unique case (k)
            K_SHORT: n = LEN_SHORT;
            K_UNI:   n = LEN_UNI;
            default: n = LEN_PLAIN;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] esc_char(input t_cmd c, input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        unique case (c.kind)
            K_PLAIN: ch = c.data;
            K_SHORT: ch = (idx == '0) ? CH_BSLASH : c.data;
            K_UNI: begin
                case (idx)
                    3'd0:         ch = CH_BSLASH;
                    3'd1:         ch = CH_U;
                    3'd2, 3'd3:   ch = CH_ZERO;
                    3'd4:         ch = hex_digit(c.data[7:4]);
                    default:      ch = hex_digit(c.data[3:0]);
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: design/json_string_escaper_top.sv
// ----------------------------------------------------------------------------
// json_string_escaper_top
// JSON string escaper: source bytes in, escaped bytes plus terminator out.
//
//   channel   valid        stall        payload
//   -------   ----------   ----------   -------------------------
//   input     i_valid      o_stall      i_in_byte
//   output    o_valid      i_stall      o_out_byte, o_run_last
//   config    i_cfg_we     -            i_cfg_wdata (buffer_size)
//
// One input item is taken per cycle while the 4-entry command queue has room.
// The emitter sends one byte per cycle while i_stall is low: one byte for a
// plain byte or the terminator, two for a short escape, six for \u00hh; that
// emitter sets the sustained rate; bytes go via the queue and output register.
// Reset is synchronous and active low; it restores buffer_size to 4096.
// Output stall backs up through the queue to o_stall.
// ----------------------------------------------------------------------------
module json_string_escaper_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [jse_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    input  logic [7:0]                 i_in_byte,
    output logic                       o_stall,
    output logic                       o_valid,
    output logic [7:0]                 o_out_byte,
    output logic                       o_run_last,
    input  logic                       i_stall
);
    import jse_pkg::*;

    t_fifo_stat w_q_stat;
    logic       w_push;
    t_cmd       w_push_cmd;
    logic       w_pop;
    t_cmd       w_head;

    jse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .o_stall    (o_stall),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd)
    );

    jse_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_cmd(w_push_cmd),
        .i_pop     (w_pop),
        .o_head    (w_head),
        .o_stat    (w_q_stat)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_q_stat  (w_q_stat),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_out_byte(o_out_byte),
        .o_run_last(o_run_last),
        .i_stall   (i_stall)
    );

endmodule

// File: design/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts source bytes, tracks the output fill level and truncation, and
// queues one command per byte that produces output.
// ----------------------------------------------------------------------------
module jse_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [jse_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    input  logic [7:0]                 i_in_byte,
    output logic                       o_stall,
    input  jse_pkg::t_fifo_stat        i_q_stat,
    output logic                       o_push,
    output jse_pkg::t_cmd              o_push_cmd
);
    import jse_pkg::*;

    logic [SIZE_W-1:0] r_buffer_size;
    logic [SIZE_W-1:0] r_bytes_used;
    logic              r_truncated;
    logic [SIZE_W-1:0] n_bytes_used;
    logic              n_truncated;

    logic              w_accept;
    t_cmd              w_cls;
    logic [IDX_W-1:0]  w_len;
    logic [SIZE_W-1:0] w_cap;
    logic [SIZE_W:0]   w_sum;
    logic              w_fits;

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;

    assign w_cls  = classify(i_in_byte);
    assign w_len  = esc_len(w_cls.kind);
    assign w_cap  = (r_buffer_size == '0) ? '0 : r_buffer_size - 1'b1;
    assign w_sum  = {1'b0, r_bytes_used} + {{(SIZE_W+1-IDX_W){1'b0}}, w_len};
    assign w_fits = w_sum <= {1'b0, w_cap};

    always_comb begin
        n_bytes_used    = r_bytes_used;
        n_truncated     = r_truncated;
        o_push          = 1'b0;
        o_push_cmd      = w_cls;
        if (w_accept) begin
            if (i_in_byte == CH_NUL) begin
                o_push          = 1'b1;
                o_push_cmd.kind = K_TERM;
                n_bytes_used    = '0;
                n_truncated     = 1'b0;
            end else if (!r_truncated) begin
                if (w_fits) begin
                    o_push       = 1'b1;
                    n_bytes_used = w_sum[SIZE_W-1:0];
                end else begin
                    n_truncated = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= SIZE_RESET;
            r_bytes_used  <= '0;
            r_truncated   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buffer_size <= i_cfg_wdata;
            end
            r_bytes_used <= n_bytes_used;
            r_truncated  <= n_truncated;
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_used <= MAX_USED)
        else $error("fill count beyond any capacity");

    a_trunc_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_truncated) |-> (o_push_cmd.kind == K_TERM))
        else $error("output queued while truncated");

endmodule

// File: design/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Small command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module jse_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  jse_pkg::t_cmd       i_push_cmd,
    input  logic                i_pop,
    output jse_pkg::t_cmd       o_head,
    output jse_pkg::t_fifo_stat o_stat
);
    import jse_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    localparam logic [FIFO_AW:0] DEPTH_CNT = FIFO_AW'(FIFO_DEPTH) == '0 ?
        {1'b1, {FIFO_AW{1'b0}}} : (FIFO_AW+1)'(FIFO_DEPTH);

    assign o_stat.full  = (r_count == DEPTH_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

// File: design/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Pops commands and emits their escaped bytes, one per cycle while i_stall is low, through an
// output register.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jse_pkg::t_cmd       i_head,
    input  jse_pkg::t_fifo_stat i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last,
    input  logic                i_stall
);
    import jse_pkg::*;

    logic             r_busy;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_out_byte;
    logic             r_run_last;

    logic             w_adv;
    logic             w_emit;
    t_cmd             w_cur;
    logic [IDX_W-1:0] w_idx;
    logic             w_last;

    assign w_adv  = !r_valid || !i_stall;
    assign o_pop  = w_adv && !r_busy && !i_q_stat.empty;
    assign w_emit = w_adv && (r_busy || !i_q_stat.empty);
    assign w_cur  = r_busy ? r_cmd : i_head;
    assign w_idx  = r_busy ? r_idx : '0;
    assign w_last = (w_idx == esc_len(w_cur.kind) - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid    <= 1'b1;
            r_out_byte <= esc_char(w_cur, w_idx);
            r_run_last <= w_last;
            r_busy     <= !w_last;
            r_cmd      <= w_cur;
            r_idx      <= w_idx + 1'b1;
        end else if (w_adv) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_run_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != '0 && r_idx < esc_len(r_cmd.kind)))
        else $error("escape index out of range");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out_byte == CH_NUL) |-> r_run_last)
        else $error("terminator not marked last");

endmodule
